// ----- sv/sbpfc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbpfc_pkg
// Shared codes, constants and types of the servo bus packet framer/checker.
// ----------------------------------------------------------------------------
package sbpfc_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int STEP_W      = 3;

   localparam logic [7:0]  SYNC_BYTE       = 8'hFF;
   localparam logic [7:0]  BROADCAST_ID    = 8'hFE;
   localparam logic [7:0]  READ_TO_TIMEOUT = 8'd255;
   localparam logic [7:0]  CHECKSUM_OK     = 8'hFF;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd5000;

   // request commands
   localparam logic [2:0] CMD_TX_BEGIN = 3'd0;
   localparam logic [2:0] CMD_TX_PARAM = 3'd1;
   localparam logic [2:0] CMD_RX_BEGIN = 3'd2;
   localparam logic [2:0] CMD_RX_BYTE  = 3'd3;
   localparam logic [2:0] CMD_IDLE     = 3'd4;

   // response kinds
   localparam logic [1:0] KIND_TX      = 2'd0;
   localparam logic [1:0] KIND_RX      = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;

   // receive status
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_TIMEOUT  = 3'd1;
   localparam logic [2:0] ST_HEADER   = 3'd2;
   localparam logic [2:0] ST_ID       = 3'd3;
   localparam logic [2:0] ST_LENGTH   = 3'd4;
   localparam logic [2:0] ST_CHECKSUM = 3'd5;

   // job opcodes between front and back
   localparam logic [1:0] JOB_TX_HDR  = 2'd0;
   localparam logic [1:0] JOB_TX_BYTE = 2'd1;
   localparam logic [1:0] JOB_RX_BYTE = 2'd2;
   localparam logic [1:0] JOB_VERDICT = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] id;
      logic [7:0] len;
      logic [7:0] instr;
      logic [7:0] data;
      logic [7:0] index;
      logic       chk_en;
      logic [7:0] chk;
      logic       vd_en;
      logic [7:0] vd_len;
      logic [7:0] vd_count;
      logic [2:0] vd_status;
   } job_type;

endpackage

// ----- sv/sbpfc_front.sv -----
// ----------------------------------------------------------------------------
// sbpfc_front
// Accepts requests, keeps the protocol state and makes jobs of those with output.
// ----------------------------------------------------------------------------
module sbpfc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_command,
   input  logic [7:0]          req_servo_id,
   input  logic [7:0]          req_instruction,
   input  logic [7:0]          req_param_count,
   input  logic [7:0]          req_data_byte,
   input  logic [7:0]          req_expected_length,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [15:0]         csr_timeout_limit,
   input  logic                q_full,
   output logic                q_push,
   output sbpfc_pkg::job_type  q_job
);

   typedef struct packed {
      logic [7:0] count;
      logic [2:0] status;
   } verdict_type;

   function automatic verdict_type judge(input logic [7:0] len, input logic timed_out,
                                         input logic [7:0] expct, input logic [7:0] txid,
                                         input logic hok, input logic idok,
                                         input logic [7:0] lf, input logic [7:0] sum);
      verdict_type v;
      v.count  = len;
      v.status = sbpfc_pkg::ST_OK;
      if (txid != sbpfc_pkg::BROADCAST_ID) begin
         if (timed_out && expct != sbpfc_pkg::READ_TO_TIMEOUT) begin
            v.status = sbpfc_pkg::ST_TIMEOUT;
         end else if (len > 8'd3) begin
            if (!hok) begin
               v.status = sbpfc_pkg::ST_HEADER;
            end else if (!idok) begin
               v.status = sbpfc_pkg::ST_ID;
            end else if (lf != len - 8'd4) begin
               v.status = sbpfc_pkg::ST_LENGTH;
            end else if (sum != sbpfc_pkg::CHECKSUM_OK) begin
               v.status = sbpfc_pkg::ST_CHECKSUM;
            end
         end
         if (v.status != sbpfc_pkg::ST_OK) v.count = 8'd0;
      end
      return v;
   endfunction

   logic [15:0] timeout_limit_ff, timeout_limit_in;
   logic [7:0]  last_tx_id_ff, last_tx_id_in;
   logic [7:0]  tx_sum_ff, tx_sum_in;
   logic [7:0]  params_left_ff, params_left_in;
   logic [7:0]  tx_index_ff, tx_index_in;
   logic        rx_active_ff, rx_active_in;
   logic [7:0]  rx_expected_ff, rx_expected_in;
   logic [7:0]  rx_received_ff, rx_received_in;
   logic [7:0]  rx_sum_ff, rx_sum_in;
   logic        header_ok_ff, header_ok_in;
   logic        id_ok_ff, id_ok_in;
   logic [7:0]  length_field_ff, length_field_in;
   logic [15:0] idle_ticks_ff, idle_ticks_in;

   logic        accept;
   logic [7:0]  lenb;
   logic [7:0]  sum_tmp;
   logic [7:0]  left_tmp;
   verdict_type vd;

   assign req_stall = q_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      last_tx_id_in   = last_tx_id_ff;
      tx_sum_in       = tx_sum_ff;
      params_left_in  = params_left_ff;
      tx_index_in     = tx_index_ff;
      rx_active_in    = rx_active_ff;
      rx_expected_in  = rx_expected_ff;
      rx_received_in  = rx_received_ff;
      rx_sum_in       = rx_sum_ff;
      header_ok_in    = header_ok_ff;
      id_ok_in        = id_ok_ff;
      length_field_in = length_field_ff;
      idle_ticks_in   = idle_ticks_ff;
      lenb            = req_param_count + 8'd2;
      sum_tmp         = '0;
      left_tmp        = '0;
      vd              = '0;
      q_push          = 1'b0;
      q_job           = '0;
      if (accept) begin
         unique case (req_command)
            sbpfc_pkg::CMD_TX_BEGIN: begin
               sum_tmp        = req_servo_id + lenb + req_instruction;
               rx_active_in   = 1'b0;
               last_tx_id_in  = req_servo_id;
               params_left_in = req_param_count;
               tx_sum_in      = sum_tmp;
               tx_index_in    = (req_param_count == 8'd0) ? 8'd6 : 8'd5;
               q_push         = 1'b1;
               q_job.op       = sbpfc_pkg::JOB_TX_HDR;
               q_job.id       = req_servo_id;
               q_job.len      = lenb;
               q_job.instr    = req_instruction;
               q_job.chk_en   = (req_param_count == 8'd0);
               q_job.chk      = ~sum_tmp;
            end
            sbpfc_pkg::CMD_TX_PARAM: begin
               if (params_left_ff != 8'd0) begin
                  sum_tmp        = tx_sum_ff + req_data_byte;
                  left_tmp       = params_left_ff - 8'd1;
                  tx_sum_in      = sum_tmp;
                  params_left_in = left_tmp;
                  tx_index_in    = tx_index_ff + ((left_tmp == 8'd0) ? 8'd2 : 8'd1);
                  q_push         = 1'b1;
                  q_job.op       = sbpfc_pkg::JOB_TX_BYTE;
                  q_job.data     = req_data_byte;
                  q_job.index    = tx_index_ff;
                  q_job.chk_en   = (left_tmp == 8'd0);
                  q_job.chk      = ~sum_tmp;
               end
            end
            sbpfc_pkg::CMD_RX_BEGIN: begin
               rx_active_in    = 1'b1;
               rx_expected_in  = req_expected_length;
               rx_received_in  = 8'd0;
               rx_sum_in       = 8'd0;
               header_ok_in    = 1'b1;
               id_ok_in        = 1'b1;
               length_field_in = 8'd0;
               idle_ticks_in   = 16'd0;
               if (req_expected_length == 8'd0) begin
                  vd              = judge(8'd0, 1'b0, req_expected_length, last_tx_id_ff,
                                          1'b1, 1'b1, 8'd0, 8'd0);
                  rx_active_in    = 1'b0;
                  q_push          = 1'b1;
                  q_job.op        = sbpfc_pkg::JOB_VERDICT;
                  q_job.vd_en     = 1'b1;
                  q_job.vd_len    = 8'd0;
                  q_job.vd_count  = vd.count;
                  q_job.vd_status = vd.status;
               end
            end
            sbpfc_pkg::CMD_RX_BYTE: begin
               if (rx_active_ff) begin
                  if (rx_received_ff < 8'd2) begin
                     if (req_data_byte != sbpfc_pkg::SYNC_BYTE) header_ok_in = 1'b0;
                  end else begin
                     if (rx_received_ff == 8'd2) id_ok_in = (req_data_byte == last_tx_id_ff);
                     if (rx_received_ff == 8'd3) length_field_in = req_data_byte;
                     rx_sum_in = rx_sum_ff + req_data_byte;
                  end
                  rx_received_in = rx_received_ff + 8'd1;
                  idle_ticks_in  = 16'd0;
                  q_push         = 1'b1;
                  q_job.op       = sbpfc_pkg::JOB_RX_BYTE;
                  q_job.data     = req_data_byte;
                  q_job.index    = rx_received_ff;
                  if (rx_received_in == rx_expected_ff) begin
                     vd              = judge(rx_received_in, 1'b0, rx_expected_ff,
                                             last_tx_id_ff, header_ok_in, id_ok_in,
                                             length_field_in, rx_sum_in);
                     rx_active_in    = 1'b0;
                     q_job.vd_en     = 1'b1;
                     q_job.vd_len    = rx_received_in;
                     q_job.vd_count  = vd.count;
                     q_job.vd_status = vd.status;
                  end
               end
            end
            sbpfc_pkg::CMD_IDLE: begin
               if (rx_active_ff) begin
                  if (idle_ticks_ff >= timeout_limit_ff) begin
                     vd              = judge(rx_received_ff, 1'b1, rx_expected_ff,
                                             last_tx_id_ff, header_ok_ff, id_ok_ff,
                                             length_field_ff, rx_sum_ff);
                     rx_active_in    = 1'b0;
                     q_push          = 1'b1;
                     q_job.op        = sbpfc_pkg::JOB_VERDICT;
                     q_job.vd_en     = 1'b1;
                     q_job.vd_len    = rx_received_ff;
                     q_job.vd_count  = vd.count;
                     q_job.vd_status = vd.status;
                  end else begin
                     idle_ticks_in = idle_ticks_ff + 16'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign timeout_limit_in = (csr_valid && csr_ready) ? csr_timeout_limit : timeout_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_limit_ff <= sbpfc_pkg::TIMEOUT_RESET;
         last_tx_id_ff    <= '0;
         tx_sum_ff        <= '0;
         params_left_ff   <= '0;
         tx_index_ff      <= '0;
         rx_active_ff     <= 1'b0;
         rx_expected_ff   <= '0;
         rx_received_ff   <= '0;
         rx_sum_ff        <= '0;
         header_ok_ff     <= 1'b1;
         id_ok_ff         <= 1'b1;
         length_field_ff  <= '0;
         idle_ticks_ff    <= '0;
      end else begin
         timeout_limit_ff <= timeout_limit_in;
         last_tx_id_ff    <= last_tx_id_in;
         tx_sum_ff        <= tx_sum_in;
         params_left_ff   <= params_left_in;
         tx_index_ff      <= tx_index_in;
         rx_active_ff     <= rx_active_in;
         rx_expected_ff   <= rx_expected_in;
         rx_received_ff   <= rx_received_in;
         rx_sum_ff        <= rx_sum_in;
         header_ok_ff     <= header_ok_in;
         id_ok_ff         <= id_ok_in;
         length_field_ff  <= length_field_in;
         idle_ticks_ff    <= idle_ticks_in;
      end
   end

endmodule

// ----- sv/sbpfc_queue.sv -----
// ----------------------------------------------------------------------------
// sbpfc_queue
// Small job queue between the front and the back end.
// ----------------------------------------------------------------------------
module sbpfc_queue #(
   parameter int DEPTH = sbpfc_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sbpfc_pkg::job_type  push_job,
   output logic                full,
   input  logic                pop,
   output sbpfc_pkg::job_type  head,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   sbpfc_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("job pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("job popped from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_CNT)
      else $error("queue count out of range");

endmodule

// ----- sv/sbpfc_back.sv -----
// ----------------------------------------------------------------------------
// sbpfc_back
// Expands jobs into response items in an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module sbpfc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  sbpfc_pkg::job_type  q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_out_byte,
   output logic [7:0]          rsp_byte_index,
   output logic                rsp_last,
   output logic [7:0]          rsp_rx_count,
   output logic [2:0]          rsp_rx_status
);

   localparam logic [sbpfc_pkg::STEP_W-1:0] MAX_STEP = sbpfc_pkg::STEP_W'(5);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [7:0] byte_index;
      logic       last;
      logic [7:0] rx_count;
      logic [2:0] rx_status;
   } result_type;

   logic [sbpfc_pkg::STEP_W-1:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type res;
   result_type vres;
   logic       final_step;
   logic       load;

   assign load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      vres            = '0;
      vres.kind       = sbpfc_pkg::KIND_VERDICT;
      vres.byte_index = q_head.vd_len;
      vres.last       = 1'b1;
      vres.rx_count   = q_head.vd_count;
      vres.rx_status  = q_head.vd_status;
   end

   always_comb begin
      res        = '0;
      final_step = 1'b1;
      unique case (q_head.op)
         sbpfc_pkg::JOB_TX_HDR: begin
            res.kind       = sbpfc_pkg::KIND_TX;
            res.byte_index = {{(8 - sbpfc_pkg::STEP_W){1'b0}}, step_ff};
            final_step     = q_head.chk_en ? (step_ff == MAX_STEP) : (step_ff == MAX_STEP - 1'b1);
            case (step_ff)
               3'd0, 3'd1: res.out_byte = sbpfc_pkg::SYNC_BYTE;
               3'd2:       res.out_byte = q_head.id;
               3'd3:       res.out_byte = q_head.len;
               3'd4:       res.out_byte = q_head.instr;
               default: begin
                  res.out_byte = q_head.chk;
                  res.last     = 1'b1;
               end
            endcase
         end
         sbpfc_pkg::JOB_TX_BYTE: begin
            res.kind   = sbpfc_pkg::KIND_TX;
            final_step = q_head.chk_en ? (step_ff != '0) : 1'b1;
            if (step_ff == '0) begin
               res.out_byte   = q_head.data;
               res.byte_index = q_head.index;
            end else begin
               res.out_byte   = q_head.chk;
               res.byte_index = q_head.index + 8'd1;
               res.last       = 1'b1;
            end
         end
         sbpfc_pkg::JOB_RX_BYTE: begin
            final_step = q_head.vd_en ? (step_ff != '0) : 1'b1;
            if (step_ff == '0) begin
               res.kind       = sbpfc_pkg::KIND_RX;
               res.out_byte   = q_head.data;
               res.byte_index = q_head.index;
            end else begin
               res = vres;
            end
         end
         default: begin
            res = vres;
         end
      endcase
   end

   assign q_pop        = load && !q_empty && final_step;
   assign rsp_valid_in = load ? !q_empty : rsp_valid_ff;

   always_comb begin
      step_in = step_ff;
      if (load && !q_empty) step_in = final_step ? '0 : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && !q_empty) rsp_ff <= res;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_out_byte   = rsp_ff.out_byte;
   assign rsp_byte_index = rsp_ff.byte_index;
   assign rsp_last       = rsp_ff.last;
   assign rsp_rx_count   = rsp_ff.rx_count;
   assign rsp_rx_status  = rsp_ff.rx_status;

   a_step_range: assert property (@(posedge clock) disable iff (reset) step_ff <= MAX_STEP)
      else $error("burst step out of range");
   a_step_has_job: assert property (@(posedge clock) disable iff (reset)
                                    step_ff != '0 |-> !q_empty)
      else $error("burst in progress without a queued job");
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("response valid right after reset");

endmodule

// ----- sv/servo_bus_packet_framer_checker.sv -----
// ----------------------------------------------------------------------------
// servo_bus_packet_framer_checker
// Half-duplex servo bus packet framer for transmit and status checker for receive.
// ----------------------------------------------------------------------------
// Requests enter on req_* (valid/stall); req_command selects begin transmit,
// transmit parameter byte, begin receive, received byte or idle tick.
// Responses leave on rsp_* (valid/stall): transmit bytes, received byte echoes
// and receive verdicts. csr_* writes timeout_limit (valid/ready, always ready).
// A request is classified in the front end in its accept cycle and, if it yields
// output, queued as a job; the back end expands each job into 1 to 6 responses,
// one per cycle while rsp_stall is low. A first response passes the queue and then
// the output register. Throughput: one request per cycle while the job queue has
// room; one response per cycle out while not stalled. A begin transmit yields 5
// or 6 responses, others 0 to 2, so the response port sets the sustained rate.
// req_stall rises when the job queue (QUEUE_DEPTH jobs) is full; a stalled
// response holds its payload and the back end stops, filling the queue.
// Reset (synchronous) clears all protocol state, empties the queue and loads
// timeout_limit with 5000.
// ----------------------------------------------------------------------------
module servo_bus_packet_framer_checker #(
   parameter int QUEUE_DEPTH = sbpfc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_servo_id,
   input  logic [7:0]  req_instruction,
   input  logic [7:0]  req_param_count,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_expected_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [7:0]  rsp_byte_index,
   output logic        rsp_last,
   output logic [7:0]  rsp_rx_count,
   output logic [2:0]  rsp_rx_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_timeout_limit
);

   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_empty;
   sbpfc_pkg::job_type q_job;
   sbpfc_pkg::job_type q_head;

   sbpfc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_servo_id        (req_servo_id),
      .req_instruction     (req_instruction),
      .req_param_count     (req_param_count),
      .req_data_byte       (req_data_byte),
      .req_expected_length (req_expected_length),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_timeout_limit   (csr_timeout_limit),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_job               (q_job)
   );

   sbpfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   sbpfc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_last       (rsp_last),
      .rsp_rx_count   (rsp_rx_count),
      .rsp_rx_status  (rsp_rx_status)
   );

endmodule
